[src/jsu_pkg.sv]
// Package for the JSON string unescape block: word types, phase codes,
// result kinds, character constants and the hex digit decoder.
// No dependencies.
package jsu_pkg;

  localparam int CapW = 11;
  localparam int AccW = 12;

  localparam logic [CapW-1:0] CapReset = 11'd256;

  // Result kinds
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindDone  = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;
  localparam logic [1:0] KindBad   = 2'd3;

  // Characters
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChFf    = 8'h0C;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6,
    PH_SKIP = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
  } out_word_t;

  typedef struct packed {
    phase_t            phase;
    logic [AccW-1:0]   hex_acc;
    logic [CapW-1:0]   stored_count;
  } dec_state_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } dec_result_t;

  // Hex digit decode: bit 4 set marks a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[src/jsu_decode.sv]
// One-step decoder for the JSON string unescape block: next state and
// optional result word for one input byte.
// Depends on jsu_pkg.
module jsu_decode (
  input  jsu_pkg::in_word_t                 in_word,
  input  logic [jsu_pkg::CapW-1:0]          capacity,
  input  jsu_pkg::dec_state_t               state,
  output jsu_pkg::dec_state_t               state_next,
  output jsu_pkg::dec_result_t              result
);

  logic [7:0]  b;
  logic        last;
  logic [4:0]  hd;
  logic [15:0] hv;
  logic        emit;
  logic [7:0]  emit_c;
  logic [7:0]  emit_disp;
  logic        room;
  logic        fin;
  logic [1:0]  fin_kind;

  assign b    = in_word.data_byte;
  assign last = in_word.is_last;
  assign hd   = jsu_pkg::hex_digit(b);
  assign hv   = {state.hex_acc, hd[3:0]};

  // Classify the byte against the current phase
  always_comb begin
    emit       = 1'b0;
    emit_c     = b;
    fin        = 1'b0;
    fin_kind   = jsu_pkg::KindBad;
    state_next = state;
    unique case (state.phase)
      jsu_pkg::PH_WAIT: begin
        if (b != jsu_pkg::ChQuote || capacity == '0 || last) begin
          fin = 1'b1;
        end else begin
          state_next.stored_count = '0;
          state_next.hex_acc      = '0;
          state_next.phase        = jsu_pkg::PH_STR;
        end
      end
      jsu_pkg::PH_STR: begin
        if (b == jsu_pkg::ChQuote) begin
          fin      = 1'b1;
          fin_kind = (state.stored_count != '0) ? jsu_pkg::KindDone : jsu_pkg::KindEmpty;
        end else if (last) begin
          fin = 1'b1;
        end else if (b == jsu_pkg::ChBsl) begin
          state_next.phase = jsu_pkg::PH_ESC;
        end else begin
          emit = 1'b1;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (last) begin
          fin = 1'b1;
        end else if (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBsl || b == jsu_pkg::ChSlash) begin
          emit = 1'b1;
        end else if (b == jsu_pkg::ChB) begin
          emit   = 1'b1;
          emit_c = jsu_pkg::ChBs;
        end else if (b == jsu_pkg::ChF) begin
          emit   = 1'b1;
          emit_c = jsu_pkg::ChFf;
        end else if (b == jsu_pkg::ChN || b == jsu_pkg::ChR || b == jsu_pkg::ChT) begin
          emit   = 1'b1;
          emit_c = jsu_pkg::ChSpace;
        end else if (b == jsu_pkg::ChU) begin
          state_next.hex_acc = '0;
          state_next.phase   = jsu_pkg::PH_HEX1;
        end else begin
          fin = 1'b1;
        end
      end
      jsu_pkg::PH_SKIP: begin
        if (last) state_next.phase = jsu_pkg::PH_WAIT;
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
        if (!hd[4] || last) begin
          fin = 1'b1;
        end else begin
          state_next.hex_acc = {state.hex_acc[jsu_pkg::AccW-5:0], hd[3:0]};
          state_next.phase   = jsu_pkg::phase_t'(state.phase + 3'd1);
        end
      end
      jsu_pkg::PH_HEX4: begin
        if (!hd[4] || last) begin
          fin = 1'b1;
        end else begin
          state_next.hex_acc = '0;
          emit   = 1'b1;
          emit_c = (hv[15:8] == 8'd0 && hv[7:0] >= 8'd32) ? hv[7:0] : jsu_pkg::ChQmark;
        end
      end
      default: begin
        state_next = state;
      end
    endcase

    // Store and report a decoded byte while room remains
    emit_disp = (emit_c < 8'd32) ? jsu_pkg::ChSpace : emit_c;
    room = ({1'b0, state.stored_count} + 12'd1) < {1'b0, capacity};
    result.valid = 1'b0;
    result.word.result_kind = fin_kind;
    result.word.out_byte = 8'd0;
    if (emit) begin
      state_next.phase = jsu_pkg::PH_STR;
      if (room) begin
        state_next.stored_count = state.stored_count + 11'd1;
        result.valid = 1'b1;
        result.word.result_kind = jsu_pkg::KindByte;
        result.word.out_byte = emit_disp;
      end
    end
    // End the string: wait for the next quote or skip the rest
    if (fin) begin
      result.valid     = 1'b1;
      state_next.phase = last ? jsu_pkg::PH_WAIT : jsu_pkg::PH_SKIP;
    end
  end

endmodule

[src/json_string_unescape_top.sv]
// JSON string unescape top level: input register, decode step, result register.
// An accepted word waits in the input register until the result register can
// take its outcome. Throughput: one byte per cycle unless the result side stalls;
// the single-step decoder sets it. Reset: phase waits for an opening quote, count
// and accumulator clear, capacity returns to 256. Depends on jsu_pkg, jsu_decode.
module json_string_unescape_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  jsu_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output jsu_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [jsu_pkg::CapW-1:0]    cfg_data
);

  logic                     in_full;
  jsu_pkg::in_word_t        in_reg;
  logic [jsu_pkg::CapW-1:0] capacity;
  jsu_pkg::dec_state_t      state;
  jsu_pkg::dec_state_t      state_next;
  jsu_pkg::dec_result_t     result;
  logic                     step;

  // Advance the held word when the result register can take its outcome
  assign step      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || step;
  assign cfg_ready = 1'b1;

  jsu_decode u_decode (
    .in_word    (in_reg),
    .capacity   (capacity),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= jsu_pkg::CapReset;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= in_data;
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= jsu_pkg::PH_WAIT;
      state.hex_acc      <= '0;
      state.stored_count <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  // Result register: load on a step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) out_data <= result.word;
  end

endmodule

[tb/sv/jsu_checker.sv]
// Checker for json_string_unescape_top: watches the input, result and capacity
// channels, predicts every decoded word and compares it with the block's output.
// Depends on jsu_pkg.
module jsu_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  jsu_pkg::in_word_t        in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  jsu_pkg::out_word_t       out_data,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [jsu_pkg::CapW-1:0] cfg_data,
  output int                       pending,
  output int                       fails
);
  import jsu_pkg::*;

  // lowest byte value that is shown as it is
  localparam logic [7:0] PrintMin = 8'd32;

  // decoder state as the checker sees it
  phase_t          ph;
  logic [AccW-1:0] hex_acc;
  logic [CapW-1:0] kept;
  logic [CapW-1:0] cap;

  out_word_t pending_decodes[$];
  int        fail_total = 0;

  // value of a hex digit character, -1 when it is no hex digit
  function automatic int digit_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  // close the string with a status word; skip the rest unless the document ends
  function automatic bit end_string(input logic [1:0] kind, input logic last,
                                    output out_word_t r);
    r.result_kind = kind;
    r.out_byte    = '0;
    ph = last ? PH_WAIT : PH_SKIP;
    return 1'b1;
  endfunction

  // store one decoded byte while room remains, drop it otherwise
  function automatic bit keep_byte(input logic [7:0] c, output out_word_t r);
    ph = PH_STR;
    if (c < PrintMin) c = ChSpace;
    r = '0;
    if (int'(kept) + 1 < int'(cap)) begin
      kept = kept + 1'b1;
      r.result_kind = KindByte;
      r.out_byte    = c;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the decoder by one raw byte; returns 1 when a word is due
  function automatic bit unescape_step(input in_word_t w, output out_word_t r);
    int          d;
    logic [15:0] v;
    r = '0;
    case (ph)
      PH_WAIT: begin
        if (w.data_byte != ChQuote || cap == '0 || w.is_last)
          return end_string(KindBad, w.is_last, r);
        kept    = '0;
        hex_acc = '0;
        ph      = PH_STR;
        return 1'b0;
      end
      PH_STR: begin
        if (w.data_byte == ChQuote)
          return end_string(kept != '0 ? KindDone : KindEmpty, w.is_last, r);
        if (w.is_last) return end_string(KindBad, 1'b1, r);
        if (w.data_byte == ChBsl) begin
          ph = PH_ESC;
          return 1'b0;
        end
        return keep_byte(w.data_byte, r);
      end
      PH_ESC: begin
        if (w.is_last) return end_string(KindBad, 1'b1, r);
        case (w.data_byte)
          ChQuote, ChBsl, ChSlash: return keep_byte(w.data_byte, r);
          ChB: return keep_byte(ChBs, r);
          ChF: return keep_byte(ChFf, r);
          ChN, ChR, ChT: return keep_byte(ChSpace, r);
          ChU: begin
            hex_acc = '0;
            ph      = PH_HEX1;
            return 1'b0;
          end
          default: return end_string(KindBad, 1'b0, r);
        endcase
      end
      PH_SKIP: begin
        if (w.is_last) ph = PH_WAIT;
        return 1'b0;
      end
      default: begin
        d = digit_value(w.data_byte);
        if (d < 0 || w.is_last) return end_string(KindBad, w.is_last, r);
        if (ph != PH_HEX4) begin
          hex_acc = {hex_acc[AccW-5:0], d[3:0]};
          ph      = ph.next();
          return 1'b0;
        end
        // fourth digit: map values outside 32..255 to a question mark
        v       = {hex_acc, d[3:0]};
        hex_acc = '0;
        return keep_byte((v >= 16'd32 && v <= 16'd255) ? v[7:0] : ChQmark, r);
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    $display("%0t jsu_checker: %s expected %0d actual %0d", $time, what, want, got);
    fail_total++;
  endfunction

  // compare each result word with the oldest prediction, then predict new input
  always @(posedge clk) begin : watch
    out_word_t predicted;
    out_word_t head;
    if (rst) begin
      ph      = PH_WAIT;
      hex_acc = '0;
      kept    = '0;
      cap     = CapReset;
      pending_decodes.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          note_mismatch("word with nothing predicted, kind", -1, out_data.result_kind);
        end else begin
          head = pending_decodes.pop_front();
          if (out_data.result_kind !== head.result_kind)
            note_mismatch("result_kind", head.result_kind, out_data.result_kind);
          if (out_data.out_byte !== head.out_byte)
            note_mismatch("out_byte", head.out_byte, out_data.out_byte);
        end
      end
      if (in_valid && in_ready) begin
        if (unescape_step(in_data, predicted)) pending_decodes.push_back(predicted);
      end
    end
    pending <= pending_decodes.size();
    fails   <= fail_total;
  end

endmodule

[tb/sv/tb.sv]
// Top of the testbench for json_string_unescape_top: clock, reset, byte stream
// stimulus with bursts and stalls, capacity phases and the final verdict.
// Depends on jsu_pkg, json_string_unescape_top and jsu_checker.
module tb;
  import jsu_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 6;
  localparam int PhaseWords  = 150;
  localparam int PhaseCount  = 8;

  // escape letters that keep or map a character, and bytes that are no hex digit
  localparam logic [7:0][7:0] EscLetters = {ChQuote, ChBsl, ChSlash, ChB, ChF, ChN, ChR, ChT};
  localparam logic [9:0][7:0] NotHex = {8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00,
                                        8'hFF, 8'h7A, ChQuote};

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  in_word_t        in_data   = '0;
  logic            out_ready = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [CapW-1:0] cfg_data  = '0;
  logic            in_ready;
  logic            out_valid;
  logic            cfg_ready;
  out_word_t       out_data;
  int              pending;
  int              fails;

  int cycle_count = 0;
  int burst_left  = 0;
  int sent        = 0;
  int stall_mode  = 0;
  int mode_left   = 0;

  logic [7:0] doc_q[$];

  json_string_unescape_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  jsu_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fails     (fails)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stall the result side: always ready, coin flip, or mostly stalled
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(5, 60);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // end the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // send one word, opening a new burst after a random gap when the last one is used up
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, is_last: last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_q.size(); i++) send_word(doc_q[i], i == doc_q.size() - 1);
  endtask

  // hold the input until every predicted word is out and the pipeline is empty
  task automatic drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  // append a \u escape; a bad digit replaces digit bad_at (4 means none)
  task automatic add_unicode(input int bad_at);
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = 16'($urandom_range(0, 31));
      1: v = 16'($urandom_range(32, 255));
      default: v = 16'($urandom_range(256, 65535));
    endcase
    doc_q.push_back(ChBsl);
    doc_q.push_back(ChU);
    for (int i = 0; i < 4; i++) begin
      if (i == bad_at) begin
        doc_q.push_back(NotHex[$urandom_range(0, 9)]);
        return;
      end
      doc_q.push_back(hex_char(v[15-4*i -: 4]));
    end
  endtask

  task automatic add_token();
    logic [7:0] b;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      do b = 8'($urandom_range(0, 255)); while (b == ChQuote || b == ChBsl);
      doc_q.push_back(b);
    end else if (pick < 80) begin
      doc_q.push_back(ChBsl);
      doc_q.push_back(EscLetters[$urandom_range(0, 7)]);
    end else begin
      add_unicode(4);
    end
  endtask

  task automatic add_bad_escape();
    logic [7:0] b;
    bit         known;
    do begin
      b     = 8'($urandom_range(0, 255));
      known = (b == ChU);
      for (int i = 0; i < 8; i++) if (b == EscLetters[i]) known = 1'b1;
    end while (known);
    doc_q.push_back(ChBsl);
    doc_q.push_back(b);
  endtask

  // build one document: mostly well formed, some noise, bad escapes, bad hex, cut short
  task automatic build_doc(input int max_tokens);
    int flaw;
    int cut;
    doc_q.delete();
    flaw = $urandom_range(0, 99);
    if (flaw < 4) begin
      repeat ($urandom_range(1, 4)) doc_q.push_back(8'($urandom_range(0, 255)));
      if (doc_q[0] == ChQuote) doc_q[0] = 8'h7B;
      return;
    end
    doc_q.push_back(ChQuote);
    repeat ($urandom_range(0, max_tokens)) add_token();
    if (flaw < 8) begin
      add_bad_escape();
    end else if (flaw < 12) begin
      add_unicode($urandom_range(0, 3));
    end else if (flaw < 17) begin
      cut = $urandom_range(1, doc_q.size());
      while (doc_q.size() > cut) void'(doc_q.pop_back());
      return;
    end else begin
      doc_q.push_back(ChQuote);
    end
    // trailing bytes are skipped up to the end of the document
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [CapW-1:0] phase_capacity(input int p);
    case (p)
      0: return CapReset;
      1: return 11'd1;
      2: return 11'd2;
      3: return 11'd1024;
      4: return 11'($urandom_range(3, 9));
      5: return 11'd0;
      6: return 11'($urandom_range(10, 40));
      default: return 11'($urandom_range(1, 1024));
    endcase
  endfunction

  initial begin
    int phase_end;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // missing opening quote on a zero byte that ends the document
    doc_q = {8'h00};
    send_doc();
    // empty string
    doc_q.delete();
    add_text("\"\"");
    send_doc();
    // top byte, \u with mixed case, tab escape, trailing byte skipped
    doc_q.delete();
    add_text("\"");
    doc_q.push_back(8'hFF);
    add_text("\\u00Fe\\t\"x");
    send_doc();
    // bad escape letter, rest skipped
    doc_q.delete();
    add_text("\"\\qz");
    send_doc();
    // document ends inside the string
    doc_q.delete();
    add_text("\"a");
    send_doc();
    // zero capacity rejects the opening quote
    write_capacity(11'd0);
    doc_q.delete();
    add_text("\"z");
    send_doc();

    // random documents over several capacity settings
    for (int p = 0; p < PhaseCount; p++) begin
      write_capacity(phase_capacity(p));
      phase_end = sent + PhaseWords;
      while (sent < phase_end) begin
        if ($urandom_range(0, 29) == 0) drain();
        build_doc(($urandom_range(0, 9) == 0) ? 40 : 12);
        send_doc();
      end
    end

    drain();
    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
